// ----- design/bfpa_pkg.sv -----
// Shared constants, codes and types of the best-fit partition allocator.
`timescale 1ns / 1ps

package bfpa_pkg;

  localparam int MAX_PARTITIONS = 16;
  localparam int IDX_W          = $clog2(MAX_PARTITIONS);
  localparam int CNT_W          = $clog2(MAX_PARTITIONS + 1);
  localparam int SIZE_W         = 16;
  localparam int BASE_W         = 16;
  localparam int OWNER_W        = 4;
  localparam int KIND_W         = 2;
  localparam int STATUS_W       = 2;
  localparam int PCOUNT_W       = 5;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;
  localparam int S_TDATA_W      = 40;
  localparam int M_TDATA_W      = 40;

  // Register indexes (byte address is 4 * index).
  localparam logic [PADDR_W-3:0] REG_PARTITION_COUNT = '0;

  // Request kinds.
  localparam logic [KIND_W-1:0] REQ_LOAD    = 2'd0;
  localparam logic [KIND_W-1:0] REQ_ALLOC   = 2'd1;
  localparam logic [KIND_W-1:0] REQ_RELEASE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_BIG   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // Table update request.
  typedef struct packed {
    logic               load;
    logic               claim;
    logic               free;
    logic [IDX_W-1:0]   idx;
    logic [SIZE_W-1:0]  size;
    logic [BASE_W-1:0]  base;
    logic [OWNER_W-1:0] owner;
  } tbl_wr_t;

  // Registered read of one table entry.
  typedef struct packed {
    logic               busy;
    logic [SIZE_W-1:0]  size;
    logic [BASE_W-1:0]  base;
    logic [OWNER_W-1:0] owner;
  } tbl_rd_t;

endpackage

// ----- design/bfpa_table.sv -----
// Partition table: size, base and owner stores with registered read, and occupied flags.
`timescale 1ns / 1ps

module bfpa_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [bfpa_pkg::IDX_W-1:0]  rd_addr,
  output bfpa_pkg::tbl_rd_t           rd,
  input  bfpa_pkg::tbl_wr_t           wr
);

  logic [bfpa_pkg::SIZE_W-1:0]  size_mem  [bfpa_pkg::MAX_PARTITIONS];
  logic [bfpa_pkg::BASE_W-1:0]  base_mem  [bfpa_pkg::MAX_PARTITIONS];
  logic [bfpa_pkg::OWNER_W-1:0] owner_mem [bfpa_pkg::MAX_PARTITIONS];
  logic [bfpa_pkg::MAX_PARTITIONS-1:0] busy;

  // Store writes.
  always_ff @(posedge clk) begin
    if (wr.load) begin
      size_mem[wr.idx] <= wr.size;
      base_mem[wr.idx] <= wr.base;
    end
    if (wr.claim) begin
      owner_mem[wr.idx] <= wr.owner;
    end
  end

  // Occupied flags: a load or a release frees, an allocation claims.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else if (wr.load || wr.free) begin
      busy[wr.idx] <= 1'b0;
    end else if (wr.claim) begin
      busy[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd.busy  <= busy[rd_addr];
    rd.size  <= size_mem[rd_addr];
    rd.base  <= base_mem[rd_addr];
    rd.owner <= owner_mem[rd_addr];
  end

endmodule

// ----- design/best_fit_partition_allocator.sv -----
// Top level of the best-fit fixed partition allocator: sequencer, scan unit and ports.
`timescale 1ns / 1ps

// Usage
//   Slave stream (s_*): one request per beat; tuser carries the request kind
//   (load entry, allocate, release), tdata the owner, size, entry index and base.
//   Master stream (m_*): one result beat per request; tuser carries the status,
//   tdata the loaded, chosen or freed entry's index, base and size (zero unless ok).
//   APB port: partition_count at byte address 0, written by the user only while idle.
// Timing
//   A load or an unknown request passes from acceptance to the done state and
//   from there into the output register. Allocate and release walk the entries
//   in use through one registered read port and one compare unit, one entry a
//   cycle; a release stops at the first entry that hits. The next request is
//   accepted the cycle after the result is loaded into the output register, so
//   one request is in work at a time.
// Reset
//   Synchronous, active high: partition_count returns to 0, every entry is
//   marked free and the output holds no beat. Sizes and bases are undefined
//   until loaded, owners until claimed.
// Stall
//   A result waits in the output register while m_tready is low; a finished
//   request holds in the done state and no further request is taken until it moves.

module best_fit_partition_allocator (
  input  logic                              clk,
  input  logic                              rst,
  // request: tdata = owner_id[3:0], request_size[19:4], entry_index[23:20],
  //          entry_base[39:24]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bfpa_pkg::S_TDATA_W-1:0]    s_tdata,
  // request: tuser = req_type[1:0]
  input  logic [bfpa_pkg::KIND_W-1:0]       s_tuser,
  // result: tdata = result_index[3:0], result_base[19:4], result_size[35:20],
  //         zero fill [39:36]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bfpa_pkg::M_TDATA_W-1:0]    m_tdata,
  // result: tuser = status[1:0]
  output logic [bfpa_pkg::STATUS_W-1:0]     m_tuser,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bfpa_pkg::PADDR_W-1:0]      paddr,
  input  logic [bfpa_pkg::PDATA_W-1:0]      pwdata,
  output logic [bfpa_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  bfpa_pkg::state_t state, state_next;

  logic [bfpa_pkg::PCOUNT_W-1:0] partition_count;
  logic [bfpa_pkg::CNT_W-1:0]    n_used;

  // latched request
  logic [bfpa_pkg::KIND_W-1:0]  kind;
  logic [bfpa_pkg::OWNER_W-1:0] owner;
  logic [bfpa_pkg::SIZE_W-1:0]  req;
  logic [bfpa_pkg::IDX_W-1:0]   eidx;
  logic [bfpa_pkg::BASE_W-1:0]  ebase;

  // scan state
  logic [bfpa_pkg::CNT_W-1:0]   cnt;
  logic                         eval_vld;
  logic [bfpa_pkg::IDX_W-1:0]   eval_idx;
  logic [bfpa_pkg::SIZE_W-1:0]  largest;
  logic                         found;
  logic [bfpa_pkg::IDX_W-1:0]   best_idx;
  logic [bfpa_pkg::SIZE_W-1:0]  best_size;
  logic [bfpa_pkg::BASE_W-1:0]  best_base;

  bfpa_pkg::tbl_rd_t rd;
  bfpa_pkg::tbl_wr_t wr;

  logic in_fire, done_fire, issue, cnt_full, scan_end, is_rel, is_alloc;
  logic cand, hit;

  logic [bfpa_pkg::STATUS_W-1:0] fin_status;
  logic [bfpa_pkg::IDX_W-1:0]    fin_idx;
  logic [bfpa_pkg::SIZE_W-1:0]   fin_size;
  logic [bfpa_pkg::BASE_W-1:0]   fin_base;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign prdata = bfpa_pkg::PDATA_W'(partition_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      partition_count <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[bfpa_pkg::PADDR_W-1:2] == bfpa_pkg::REG_PARTITION_COUNT) begin
      partition_count <= pwdata[bfpa_pkg::PCOUNT_W-1:0];
    end
  end

  // Clamp the entry count to the table depth.
  assign n_used = (partition_count > bfpa_pkg::PCOUNT_W'(bfpa_pkg::MAX_PARTITIONS)) ?
                  bfpa_pkg::CNT_W'(bfpa_pkg::MAX_PARTITIONS) :
                  bfpa_pkg::CNT_W'(partition_count);

  // ---------------------------------------------------------------- control
  assign is_rel   = (kind == bfpa_pkg::REQ_RELEASE);
  assign is_alloc = (kind == bfpa_pkg::REQ_ALLOC);
  assign cnt_full = (cnt >= n_used);
  assign scan_end = !eval_vld && (cnt_full || (is_rel && found));

  always_comb begin
    state_next = state;
    unique case (state)
      bfpa_pkg::S_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == bfpa_pkg::REQ_ALLOC || s_tuser == bfpa_pkg::REQ_RELEASE) begin
            state_next = bfpa_pkg::S_SCAN;
          end else begin
            state_next = bfpa_pkg::S_DONE;
          end
        end
      end
      bfpa_pkg::S_SCAN: begin
        if (scan_end) begin
          state_next = bfpa_pkg::S_DONE;
        end
      end
      bfpa_pkg::S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = bfpa_pkg::S_IDLE;
        end
      end
      default: state_next = bfpa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    issue     = 1'b0;
    done_fire = 1'b0;
    unique case (state)
      bfpa_pkg::S_IDLE: s_tready  = 1'b1;
      bfpa_pkg::S_SCAN: issue     = !cnt_full && !(is_rel && (found || hit));
      bfpa_pkg::S_DONE: done_fire = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  assign in_fire = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfpa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------- scan unit
  // One entry read per cycle; its data is judged the following cycle.
  assign cand = !rd.busy && (rd.size >= req) && (!found || rd.size < best_size);
  assign hit  = eval_vld && is_rel && !found && rd.busy && (rd.owner == owner);

  always_ff @(posedge clk) begin
    if (rst) begin
      eval_vld <= 1'b0;
    end else begin
      eval_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind    <= s_tuser;
      owner   <= s_tdata[3:0];
      req     <= s_tdata[19:4];
      eidx    <= s_tdata[23:20];
      ebase   <= s_tdata[39:24];
      cnt     <= '0;
      largest <= '0;
      found   <= 1'b0;
    end else begin
      eval_idx <= cnt[bfpa_pkg::IDX_W-1:0];
      if (issue) begin
        cnt <= cnt + 1'b1;
      end
      if (eval_vld && is_alloc) begin
        if (rd.size > largest) begin
          largest <= rd.size;
        end
        if (cand) begin
          found     <= 1'b1;
          best_idx  <= eval_idx;
          best_size <= rd.size;
          best_base <= rd.base;
        end
      end
      if (hit) begin
        found     <= 1'b1;
        best_idx  <= eval_idx;
        best_size <= rd.size;
        best_base <= rd.base;
      end
    end
  end

  bfpa_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (cnt[bfpa_pkg::IDX_W-1:0]),
    .rd      (rd),
    .wr      (wr)
  );

  // ---------------------------------------------------------------- result
  // Too-big is judged against the largest entry in use, before fit.
  always_comb begin
    fin_status = bfpa_pkg::ST_NOT_FOUND;
    fin_idx    = best_idx;
    fin_size   = best_size;
    fin_base   = best_base;
    case (kind)
      bfpa_pkg::REQ_LOAD: begin
        fin_status = bfpa_pkg::ST_OK;
        fin_idx    = eidx;
        fin_size   = req;
        fin_base   = ebase;
      end
      bfpa_pkg::REQ_ALLOC: begin
        if (n_used == '0) begin
          fin_status = bfpa_pkg::ST_FULL;
        end else if (req > largest) begin
          fin_status = bfpa_pkg::ST_TOO_BIG;
        end else if (found) begin
          fin_status = bfpa_pkg::ST_OK;
        end else begin
          fin_status = bfpa_pkg::ST_FULL;
        end
      end
      bfpa_pkg::REQ_RELEASE: begin
        fin_status = found ? bfpa_pkg::ST_OK : bfpa_pkg::ST_NOT_FOUND;
      end
      default: fin_status = bfpa_pkg::ST_NOT_FOUND;
    endcase
  end

  // Commit the table update together with the result beat.
  always_comb begin
    wr.load  = done_fire && (kind == bfpa_pkg::REQ_LOAD);
    wr.claim = done_fire && is_alloc && (fin_status == bfpa_pkg::ST_OK);
    wr.free  = done_fire && is_rel && (fin_status == bfpa_pkg::ST_OK);
    wr.idx   = fin_idx;
    wr.size  = req;
    wr.base  = ebase;
    wr.owner = owner;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Zero the payload unless the status is ok.
  always_ff @(posedge clk) begin
    if (done_fire) begin
      m_tuser <= fin_status;
      if (fin_status == bfpa_pkg::ST_OK) begin
        m_tdata <= {4'b0, fin_size, fin_base, fin_idx};
      end else begin
        m_tdata <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_eval_in_scan: assert property (@(posedge clk) disable iff (rst)
    eval_vld |-> state == bfpa_pkg::S_SCAN)
    else $error("entry judged outside a scan");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == bfpa_pkg::S_SCAN |-> cnt <= n_used)
    else $error("scan index beyond entries in use");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != bfpa_pkg::ST_OK) |-> m_tdata == '0)
    else $error("failed result carries payload");

  a_rel_stop: assert property (@(posedge clk) disable iff (rst)
    (state == bfpa_pkg::S_SCAN && is_rel && found) |-> !issue)
    else $error("release scan continues after a hit");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready)
    else $error("second request taken while one is in work");
`endif

endmodule

// ----- dv/tb_best_fit_partition_allocator.sv -----
// Self-checking testbench of the best-fit partition allocator: stream requests in, results out.
`timescale 1ns / 1ps

module tb_best_fit_partition_allocator;

  // Request kind with no meaning; the block must answer it with not_found.
  localparam logic [bfpa_pkg::KIND_W-1:0] REQ_UNKNOWN = 2'd3;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 8;
  localparam int PHASES          = 8;
  localparam int PHASE_ITEMS     = 116;
  localparam int PRESSURE_PHASE  = 0;
  localparam int PRESSURE_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 2000;
  // Longest request is a full table walk plus the output stage; allow some slack.
  localparam int SETTLE_CYCLES   = 30;

  // partition_count per random phase: extremes 0, 16 and the all-ones value among them.
  localparam logic [bfpa_pkg::PCOUNT_W-1:0] PHASE_COUNTS [PHASES] =
    '{5'd16, 5'd1, 5'd31, 5'd8, 5'd0, 5'd16, 5'd3, 5'd12};

  typedef struct packed {
    logic [bfpa_pkg::KIND_W-1:0]  kind;
    logic [bfpa_pkg::OWNER_W-1:0] owner;
    logic [bfpa_pkg::SIZE_W-1:0]  size;
    logic [bfpa_pkg::IDX_W-1:0]   idx;
    logic [bfpa_pkg::BASE_W-1:0]  base;
  } alloc_req_t;

  typedef struct packed {
    logic [bfpa_pkg::STATUS_W-1:0] status;
    logic [bfpa_pkg::IDX_W-1:0]    idx;
    logic [bfpa_pkg::BASE_W-1:0]   base;
    logic [bfpa_pkg::SIZE_W-1:0]   size;
  } alloc_res_t;

  // One row of the directed walk. Where typed_exp is set the result is written out here,
  // otherwise the row is checked against the table predictor.
  typedef struct packed {
    logic                          cfg_wr;
    logic [bfpa_pkg::PCOUNT_W-1:0] cfg_val;
    logic [bfpa_pkg::KIND_W-1:0]   kind;
    logic [bfpa_pkg::OWNER_W-1:0]  owner;
    logic [bfpa_pkg::SIZE_W-1:0]   size;
    logic [bfpa_pkg::IDX_W-1:0]    idx;
    logic [bfpa_pkg::BASE_W-1:0]   base;
    logic                          typed_exp;
    logic [bfpa_pkg::STATUS_W-1:0] e_status;
    logic [bfpa_pkg::IDX_W-1:0]    e_idx;
    logic [bfpa_pkg::BASE_W-1:0]   e_base;
    logic [bfpa_pkg::SIZE_W-1:0]   e_size;
  } dir_row_t;

  localparam int DIR_N = 29;

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // Straight after reset the table is empty: allocate finds nothing, release finds nobody.
    '{1'b0, 5'd0,  bfpa_pkg::REQ_ALLOC,   4'd1,  16'h0001, 4'd0,  16'h0000,
      1'b1, bfpa_pkg::ST_FULL,      4'd0,  16'h0000, 16'h0000},
    '{1'b0, 5'd0,  bfpa_pkg::REQ_RELEASE, 4'd3,  16'h0000, 4'd0,  16'h0000,
      1'b1, bfpa_pkg::ST_NOT_FOUND, 4'd0,  16'h0000, 16'h0000},
    '{1'b0, 5'd0,  REQ_UNKNOWN,           4'd15, 16'hFFFF, 4'd15, 16'hFFFF,
      1'b1, bfpa_pkg::ST_NOT_FOUND, 4'd0,  16'h0000, 16'h0000},
    // Fill every entry so that no later walk reads an unwritten one.
    '{1'b0, 5'd0,  bfpa_pkg::REQ_LOAD,    4'd0,  16'h0000, 4'd0,  16'h0000,
      1'b1, bfpa_pkg::ST_OK,        4'd0,  16'h0000, 16'h0000},
    '{1'b0, 5'd0,  bfpa_pkg::REQ_LOAD,    4'd1,  16'h0064, 4'd1,  16'h1000,
      1'b1, bfpa_pkg::ST_OK,        4'd1,  16'h1000, 16'h0064},
    '{1'b0, 5'd0,  bfpa_pkg::REQ_LOAD,    4'd2,  16'h00C8, 4'd2,  16'h2000,
      1'b1, bfpa_pkg::ST_OK,        4'd2,  16'h2000, 16'h00C8},
    '{1'b0, 5'd0,  bfpa_pkg::REQ_LOAD,    4'd3,  16'h0064, 4'd3,  16'h0300,
      1'b1, bfpa_pkg::ST_OK,        4'd3,  16'h0300, 16'h0064},
    '{1'b0, 5'd0,  bfpa_pkg::REQ_LOAD,    4'd4,  16'h0400, 4'd4,  16'hA5A5,
      1'b1, bfpa_pkg::ST_OK,        4'd4,  16'hA5A5, 16'h0400},
    '{1'b0, 5'd0,  bfpa_pkg::REQ_LOAD,    4'd5,  16'h0800, 4'd5,  16'h5A5A,
      1'b1, bfpa_pkg::ST_OK,        4'd5,  16'h5A5A, 16'h0800},
    '{1'b0, 5'd0,  bfpa_pkg::REQ_LOAD,    4'd6,  16'h0032, 4'd6,  16'h0600,
      1'b1, bfpa_pkg::ST_OK,        4'd6,  16'h0600, 16'h0032},
    '{1'b0, 5'd0,  bfpa_pkg::REQ_LOAD,    4'd7,  16'h1000, 4'd7,  16'h7000,
      1'b1, bfpa_pkg::ST_OK,        4'd7,  16'h7000, 16'h1000},
    '{1'b0, 5'd0,  bfpa_pkg::REQ_LOAD,    4'd8,  16'h2000, 4'd8,  16'h8000,
      1'b1, bfpa_pkg::ST_OK,        4'd8,  16'h8000, 16'h2000},
    '{1'b0, 5'd0,  bfpa_pkg::REQ_LOAD,    4'd9,  16'h012C, 4'd9,  16'h9000,
      1'b1, bfpa_pkg::ST_OK,        4'd9,  16'h9000, 16'h012C},
    '{1'b0, 5'd0,  bfpa_pkg::REQ_LOAD,    4'd10, 16'h4000, 4'd10, 16'hAAAA,
      1'b1, bfpa_pkg::ST_OK,        4'd10, 16'hAAAA, 16'h4000},
    '{1'b0, 5'd0,  bfpa_pkg::REQ_LOAD,    4'd11, 16'h8000, 4'd11, 16'h5555,
      1'b1, bfpa_pkg::ST_OK,        4'd11, 16'h5555, 16'h8000},
    '{1'b0, 5'd0,  bfpa_pkg::REQ_LOAD,    4'd12, 16'h004B, 4'd12, 16'h0C00,
      1'b1, bfpa_pkg::ST_OK,        4'd12, 16'h0C00, 16'h004B},
    '{1'b0, 5'd0,  bfpa_pkg::REQ_LOAD,    4'd13, 16'h0001, 4'd13, 16'hD000,
      1'b1, bfpa_pkg::ST_OK,        4'd13, 16'hD000, 16'h0001},
    '{1'b0, 5'd0,  bfpa_pkg::REQ_LOAD,    4'd14, 16'hFFFE, 4'd14, 16'hFFFE,
      1'b1, bfpa_pkg::ST_OK,        4'd14, 16'hFFFE, 16'hFFFE},
    '{1'b0, 5'd0,  bfpa_pkg::REQ_LOAD,    4'd15, 16'hFFFF, 4'd15, 16'hFFFF,
      1'b1, bfpa_pkg::ST_OK,        4'd15, 16'hFFFF, 16'hFFFF},
    // Four entries in use: a request above the largest of them is too big.
    '{1'b1, 5'd4,  bfpa_pkg::REQ_ALLOC,   4'd15, 16'hFFFF, 4'd0,  16'h0000,
      1'b1, bfpa_pkg::ST_TOO_BIG,   4'd0,  16'h0000, 16'h0000},
    // Equal sizes: the lower index wins, then the other one.
    '{1'b0, 5'd0,  bfpa_pkg::REQ_ALLOC,   4'd5,  16'h0064, 4'd0,  16'h0000,
      1'b0, bfpa_pkg::ST_OK,        4'd0,  16'h0000, 16'h0000},
    '{1'b0, 5'd0,  bfpa_pkg::REQ_ALLOC,   4'd5,  16'h0064, 4'd0,  16'h0000,
      1'b0, bfpa_pkg::ST_OK,        4'd0,  16'h0000, 16'h0000},
    '{1'b0, 5'd0,  bfpa_pkg::REQ_ALLOC,   4'd0,  16'h0096, 4'd0,  16'h0000,
      1'b0, bfpa_pkg::ST_OK,        4'd0,  16'h0000, 16'h0000},
    // Only the empty entry is free and it cannot hold one position.
    '{1'b0, 5'd0,  bfpa_pkg::REQ_ALLOC,   4'd9,  16'h0001, 4'd0,  16'h0000,
      1'b0, bfpa_pkg::ST_OK,        4'd0,  16'h0000, 16'h0000},
    '{1'b0, 5'd0,  bfpa_pkg::REQ_ALLOC,   4'd0,  16'h0000, 4'd0,  16'h0000,
      1'b0, bfpa_pkg::ST_OK,        4'd0,  16'h0000, 16'h0000},
    '{1'b0, 5'd0,  bfpa_pkg::REQ_RELEASE, 4'd5,  16'h0000, 4'd0,  16'h0000,
      1'b0, bfpa_pkg::ST_OK,        4'd0,  16'h0000, 16'h0000},
    // Count above the table depth acts as the full table.
    '{1'b1, 5'd31, bfpa_pkg::REQ_ALLOC,   4'd12, 16'hFFFF, 4'd0,  16'h0000,
      1'b0, bfpa_pkg::ST_OK,        4'd0,  16'h0000, 16'h0000},
    // Reloading an occupied entry frees it, so its owner has nothing left to release.
    '{1'b0, 5'd0,  bfpa_pkg::REQ_LOAD,    4'd7,  16'h0064, 4'd3,  16'h0300,
      1'b1, bfpa_pkg::ST_OK,        4'd3,  16'h0300, 16'h0064},
    '{1'b0, 5'd0,  bfpa_pkg::REQ_RELEASE, 4'd5,  16'h0000, 4'd0,  16'h0000,
      1'b0, bfpa_pkg::ST_OK,        4'd0,  16'h0000, 16'h0000}
  };

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [bfpa_pkg::S_TDATA_W-1:0] s_tdata;
  logic [bfpa_pkg::KIND_W-1:0]    s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [bfpa_pkg::M_TDATA_W-1:0] m_tdata;
  logic [bfpa_pkg::STATUS_W-1:0]  m_tuser;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [bfpa_pkg::PADDR_W-1:0]   paddr;
  logic [bfpa_pkg::PDATA_W-1:0]   pwdata;
  logic [bfpa_pkg::PDATA_W-1:0]   prdata;
  logic                           pready;

  best_fit_partition_allocator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shadow of the partition table and of partition_count, kept in step with the block.
  logic [bfpa_pkg::SIZE_W-1:0]   tbl_size  [bfpa_pkg::MAX_PARTITIONS];
  logic [bfpa_pkg::BASE_W-1:0]   tbl_base  [bfpa_pkg::MAX_PARTITIONS];
  logic                          tbl_busy  [bfpa_pkg::MAX_PARTITIONS];
  logic [bfpa_pkg::OWNER_W-1:0]  tbl_owner [bfpa_pkg::MAX_PARTITIONS];
  logic [bfpa_pkg::PCOUNT_W-1:0] part_count;

  alloc_res_t pending_results [$];

  int err_count;
  int reqs_sent;
  int beats_checked;
  int status_seen [4];
  int tx_idle_pct;
  int rx_stall_pct;
  int phase_no;
  int quiet_cycles;
  logic pressure_done;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Print one line per mismatch and count it; the run carries on to its normal end.
  task automatic report_mismatch(input string what,
                                 input logic [bfpa_pkg::M_TDATA_W-1:0] got,
                                 input logic [bfpa_pkg::M_TDATA_W-1:0] want);
    $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // Work out the result of one request and advance the shadow table, best fit first.
  function automatic alloc_res_t table_outcome(input alloc_req_t r);
    alloc_res_t                  res;
    int                          used;
    int                          i;
    int                          best;
    logic                        hit;
    logic [bfpa_pkg::SIZE_W-1:0] largest;
    res     = '0;
    used    = (part_count > bfpa_pkg::MAX_PARTITIONS) ? bfpa_pkg::MAX_PARTITIONS :
              int'(part_count);
    best    = 0;
    hit     = 1'b0;
    largest = '0;
    case (r.kind)
      bfpa_pkg::REQ_LOAD: begin
        tbl_size[r.idx] = r.size;
        tbl_base[r.idx] = r.base;
        tbl_busy[r.idx] = 1'b0;
        res = '{bfpa_pkg::ST_OK, r.idx, r.base, r.size};
      end
      bfpa_pkg::REQ_ALLOC: begin
        for (i = 0; i < used; i++)
          if (tbl_size[i] > largest) largest = tbl_size[i];
        if (used == 0) begin
          res.status = bfpa_pkg::ST_FULL;
        end else if (r.size > largest) begin
          // The largest entry decides, whether it is occupied or not.
          res.status = bfpa_pkg::ST_TOO_BIG;
        end else begin
          for (i = 0; i < used; i++)
            if (!tbl_busy[i] && tbl_size[i] >= r.size &&
                (!hit || tbl_size[i] < tbl_size[best])) begin
              best = i;
              hit  = 1'b1;
            end
          if (!hit) begin
            res.status = bfpa_pkg::ST_FULL;
          end else begin
            tbl_busy[best]  = 1'b1;
            tbl_owner[best] = r.owner;
            res = '{bfpa_pkg::ST_OK, bfpa_pkg::IDX_W'(best), tbl_base[best],
                    tbl_size[best]};
          end
        end
      end
      bfpa_pkg::REQ_RELEASE: begin
        for (i = 0; i < used && !hit; i++)
          if (tbl_busy[i] && tbl_owner[i] == r.owner) begin
            tbl_busy[i] = 1'b0;
            hit = 1'b1;
            res = '{bfpa_pkg::ST_OK, bfpa_pkg::IDX_W'(i), tbl_base[i], tbl_size[i]};
          end
        if (!hit) res.status = bfpa_pkg::ST_NOT_FOUND;
      end
      default: begin
        res.status = bfpa_pkg::ST_NOT_FOUND;
      end
    endcase
    return res;
  endfunction

  // Random request, mostly aimed at sizes near those in the table so that fits, ties,
  // too_big and memory_full all turn up; owners favour a few ids so releases hit.
  function automatic alloc_req_t random_req();
    alloc_req_t                  r;
    int                          pick;
    int                          trim;
    logic [bfpa_pkg::SIZE_W-1:0] near;
    r       = '0;
    r.base  = bfpa_pkg::BASE_W'($urandom);
    r.idx   = bfpa_pkg::IDX_W'($urandom);
    r.owner = ($urandom_range(0, 99) < 75) ? bfpa_pkg::OWNER_W'($urandom_range(0, 7)) :
              bfpa_pkg::OWNER_W'($urandom);
    pick    = $urandom_range(0, 99);
    if (pick < 15) begin
      r.kind = bfpa_pkg::REQ_LOAD;
      pick   = $urandom_range(0, 9);
      if (pick < 8)      r.size = bfpa_pkg::SIZE_W'($urandom_range(0, 2047));
      else if (pick < 9) r.size = bfpa_pkg::SIZE_W'($urandom);
      else               r.size = $urandom_range(0, 1) ? '1 : '0;
    end else if (pick < 57) begin
      r.kind = bfpa_pkg::REQ_ALLOC;
      pick   = $urandom_range(0, 99);
      if (pick < 70) begin
        near = tbl_size[$urandom_range(0, bfpa_pkg::MAX_PARTITIONS - 1)];
        trim = $urandom_range(0, 3);
        if (pick < 10)
          r.size = (near == '1) ? near : near + 1'b1;
        else
          r.size = (near > trim) ? near - bfpa_pkg::SIZE_W'(trim) : '0;
      end else if (pick < 90) begin
        r.size = bfpa_pkg::SIZE_W'($urandom_range(0, 1023));
      end else begin
        r.size = bfpa_pkg::SIZE_W'($urandom);
      end
    end else if (pick < 97) begin
      r.kind = bfpa_pkg::REQ_RELEASE;
      r.size = bfpa_pkg::SIZE_W'($urandom);
    end else begin
      r.kind = REQ_UNKNOWN;
      r.size = bfpa_pkg::SIZE_W'($urandom);
    end
    return r;
  endfunction

  // Offer one request beat, idling first at the sender's rate, and hold it until taken.
  // Entered and left at a rising edge; the beat is predicted at the edge that accepts it.
  task automatic push_req(input alloc_req_t r, input logic use_typed, input alloc_res_t typed);
    alloc_res_t res;
    while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.kind;
    s_tdata  <= {r.base, r.idx, r.size, r.owner};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    res = table_outcome(r);
    pending_results.push_back(use_typed ? typed : res);
    reqs_sent++;
  endtask

  // Drop the request stream and wait for every outstanding result beat.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // APB write of partition_count: setup beat, then access beat until pready.
  task automatic write_count(input logic [bfpa_pkg::PCOUNT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {bfpa_pkg::REG_PARTITION_COUNT, 2'b00};
    pwdata  <= bfpa_pkg::PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    part_count = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Result sink: stall at the phase's rate, and once hold off for a long stretch so the
  // output register fills and the block stops taking requests.
  initial begin : result_sink
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (phase_no == PRESSURE_PHASE && !pressure_done) begin
        m_tready <= 1'b0;
        pressure_done = 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Compare every accepted result beat, field by field, with the oldest expectation.
  always @(posedge clk) begin : result_check
    alloc_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", m_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        beats_checked++;
        status_seen[m_tuser]++;
        if (m_tuser !== want.status)
          report_mismatch("status", bfpa_pkg::M_TDATA_W'(m_tuser),
                          bfpa_pkg::M_TDATA_W'(want.status));
        if (m_tdata[3:0] !== want.idx)
          report_mismatch("result_index", bfpa_pkg::M_TDATA_W'(m_tdata[3:0]),
                          bfpa_pkg::M_TDATA_W'(want.idx));
        if (m_tdata[19:4] !== want.base)
          report_mismatch("result_base", bfpa_pkg::M_TDATA_W'(m_tdata[19:4]),
                          bfpa_pkg::M_TDATA_W'(want.base));
        if (m_tdata[35:20] !== want.size)
          report_mismatch("result_size", bfpa_pkg::M_TDATA_W'(m_tdata[35:20]),
                          bfpa_pkg::M_TDATA_W'(want.size));
        if (m_tdata[39:36] !== 4'd0)
          report_mismatch("tdata zero fill", bfpa_pkg::M_TDATA_W'(m_tdata[39:36]), '0);
      end
    end
  end

  // Watchdog: end the run if no beat moves on either stream for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_best_fit_partition_allocator: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int         k;
    int         p;
    dir_row_t   row;
    alloc_req_t r;
    // Hold every input at a known value and the block in reset.
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    part_count    = '0;
    err_count     = 0;
    reqs_sent     = 0;
    beats_checked = 0;
    status_seen   = '{0, 0, 0, 0};
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    phase_no      = -1;
    quiet_cycles  = 0;
    pressure_done = 1'b0;
    for (k = 0; k < bfpa_pkg::MAX_PARTITIONS; k++) begin
      tbl_size[k]  = '0;
      tbl_base[k]  = '0;
      tbl_busy[k]  = 1'b0;
      tbl_owner[k] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed walk, no idling on either side.
    for (k = 0; k < DIR_N; k++) begin
      row = DIR_ROWS[k];
      if (row.cfg_wr) begin
        drain_results();
        write_count(row.cfg_val);
      end
      r = '{row.kind, row.owner, row.size, row.idx, row.base};
      push_req(r, row.typed_exp, '{row.e_status, row.e_idx, row.e_base, row.e_size});
    end

    // Random phases: four idling patterns in turn, each phase with its partition_count from the list.
    for (p = 0; p < PHASES; p++) begin
      drain_results();
      write_count(PHASE_COUNTS[p]);
      case (p % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 65; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 65; end
        default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
      endcase
      phase_no = p;
      repeat (PHASE_ITEMS) push_req(random_req(), 1'b0, '0);
    end

    // Let the last results out, then watch a little longer for stray beats.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d requests with %0d partition_count writes; %0d results checked.",
             reqs_sent, PHASES + 2, beats_checked);
    $display("Results by status: ok %0d, too_big %0d, memory_full %0d, not_found %0d.",
             status_seen[bfpa_pkg::ST_OK], status_seen[bfpa_pkg::ST_TOO_BIG],
             status_seen[bfpa_pkg::ST_FULL], status_seen[bfpa_pkg::ST_NOT_FOUND]);
    if (err_count == 0) begin
      $display("tb_best_fit_partition_allocator: PASS");
    end else begin
      $display("tb_best_fit_partition_allocator: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/bfpa_pkg.sv
design/bfpa_table.sv
design/best_fit_partition_allocator.sv
dv/tb_best_fit_partition_allocator.sv
